[hw/rtl/qr_segment_bit_packer_defines.svh]
// Assertion helpers for the segment bit packer.
`ifndef QR_SEGMENT_BIT_PACKER_DEFINES_SVH
`define QR_SEGMENT_BIT_PACKER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define QSBP_ASSERT_HOLD(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define QSBP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/qsbp_pkg.sv]
`default_nettype none

package qsbp_pkg;

  // Segment modes; selector value 3 is folded into byte mode by the front end.
  typedef enum logic [1:0] {
    MODE_NUMERIC = 2'd0,
    MODE_ALNUM   = 2'd1,
    MODE_BYTE    = 2'd2
  } seg_mode_t;

  // Group widths
  localparam logic [3:0] W_NUM1  = 4'd4;
  localparam logic [3:0] W_ALN1  = 4'd6;
  localparam logic [3:0] W_NUM2  = 4'd7;
  localparam logic [3:0] W_BYTE  = 4'd8;
  localparam logic [3:0] W_NUM3  = 4'd10;
  localparam logic [3:0] W_ALN2  = 4'd11;

  localparam logic [10:0] NUM_RADIX = 11'd10;
  localparam logic [10:0] ALN_RADIX = 11'd45;

  // Classified character handed from front to back.
  typedef struct packed {
    seg_mode_t  mode;
    logic [7:0] value;  // digit, table index or raw byte
    logic       bad;
    logic       last;
  } class_item_t;

  // One finished bit group.
  typedef struct packed {
    logic [10:0] value;
    logic [3:0]  width;
    logic        last;
    logic        bad;
  } group_t;

  // Position in the 45-character alphanumeric set; found is 0 for others.
  function automatic logic [6:0] alnum_lookup(input logic [7:0] c);
    logic [7:0] off;
    logic [6:0] res;
    off = 8'd0;
    res = 7'd0;
    if (c inside {["0":"9"]}) begin
      off = c - 8'd48;
      res = {1'b1, off[5:0]};
    end else if (c inside {["A":"Z"]}) begin
      off = c - 8'd55;
      res = {1'b1, off[5:0]};
    end else begin
      case (c)
        " ":     res = {1'b1, 6'd36};
        "$":     res = {1'b1, 6'd37};
        "%":     res = {1'b1, 6'd38};
        "*":     res = {1'b1, 6'd39};
        "+":     res = {1'b1, 6'd40};
        "-":     res = {1'b1, 6'd41};
        ".":     res = {1'b1, 6'd42};
        "/":     res = {1'b1, 6'd43};
        ":":     res = {1'b1, 6'd44};
        default: res = 7'd0;
      endcase
    end
    return res;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/qsbp_fifo.sv]
`default_nettype none

// Small register queue with first-word fall-through.
module qsbp_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rdata,
  output logic                  empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

[hw/rtl/qsbp_front.sv]
`default_nettype none

// Front end: accepts characters and classifies them for the current mode.
module qsbp_front
  import qsbp_pkg::*;
(
  input  wire logic [1:0] mode_sel,
  input  wire logic       push,
  input  wire logic [7:0] char_code,
  input  wire logic       is_last,
  input  wire logic       q_full,
  output logic            q_push,
  output class_item_t     q_item
);

  logic [6:0] aln;
  logic [7:0] dig;

  assign q_push = push && !q_full;
  assign aln    = alnum_lookup(char_code);
  assign dig    = char_code - 8'd48;

  // classify; out-of-set characters count as value 0
  always_comb begin
    q_item.last = is_last;
    case (mode_sel)
      MODE_NUMERIC: begin
        q_item.mode = MODE_NUMERIC;
        if (char_code inside {["0":"9"]}) begin
          q_item.value = {4'd0, dig[3:0]};
          q_item.bad   = 1'b0;
        end else begin
          q_item.value = 8'd0;
          q_item.bad   = 1'b1;
        end
      end
      MODE_ALNUM: begin
        q_item.mode  = MODE_ALNUM;
        q_item.value = {2'd0, aln[5:0]};
        q_item.bad   = !aln[6];
      end
      default: begin
        q_item.mode  = MODE_BYTE;
        q_item.value = char_code;
        q_item.bad   = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

[hw/rtl/qsbp_back.sv]
`default_nettype none

// Back end: holds the partial group and forms finished bit groups.
module qsbp_back
  import qsbp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        clear,
  input  wire logic        q_empty,
  input  wire class_item_t q_item,
  output logic             q_pop,
  input  wire logic        r_full,
  output logic             r_push,
  output group_t           r_item
);

  logic [6:0]  pending_value;
  logic [1:0]  pending_count;
  logic        bad_seen;
  logic [6:0]  pending_value_next;
  logic [1:0]  pending_count_next;
  logic        bad_seen_next;
  logic        emit;
  logic [1:0]  cnt;
  logic        bad_all;
  logic [10:0] num_val;
  logic [10:0] aln_val;

  assign q_pop   = !q_empty && !r_full;
  assign r_push  = q_pop && emit;
  assign cnt     = pending_count + 2'd1;
  assign bad_all = q_item.bad || bad_seen;
  assign num_val = {4'd0, pending_value} * NUM_RADIX + {3'd0, q_item.value};
  assign aln_val = {4'd0, pending_value} * ALN_RADIX + {3'd0, q_item.value};

  // group formation
  always_comb begin
    emit               = 1'b1;
    r_item.value       = 11'd0;
    r_item.width       = W_BYTE;
    r_item.last        = q_item.last;
    r_item.bad         = bad_all;
    pending_value_next = 7'd0;
    pending_count_next = 2'd0;
    bad_seen_next      = 1'b0;
    case (q_item.mode)
      MODE_NUMERIC: begin
        r_item.value = num_val;
        if (cnt == 2'd3) begin
          r_item.width = W_NUM3;
        end else if (q_item.last) begin
          r_item.width = (cnt == 2'd1) ? W_NUM1 : W_NUM2;
        end else begin
          emit               = 1'b0;
          pending_value_next = num_val[6:0];
          pending_count_next = cnt;
          bad_seen_next      = bad_all;
        end
      end
      MODE_ALNUM: begin
        if (pending_count != 2'd0) begin
          r_item.value = aln_val;
          r_item.width = W_ALN2;
        end else if (q_item.last) begin
          r_item.value = {3'd0, q_item.value};
          r_item.width = W_ALN1;
        end else begin
          emit               = 1'b0;
          pending_value_next = q_item.value[6:0];
          pending_count_next = 2'd1;
          bad_seen_next      = bad_all;
        end
      end
      default: begin
        r_item.value = {3'd0, q_item.value};
        r_item.width = W_BYTE;
        r_item.bad   = 1'b0;
      end
    endcase
  end

  // partial group state; a mode write drops it
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      pending_value <= 7'd0;
      pending_count <= 2'd0;
      bad_seen      <= 1'b0;
    end else if (q_pop) begin
      pending_value <= pending_value_next;
      pending_count <= pending_count_next;
      bad_seen      <= bad_seen_next;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/qr_segment_bit_packer.sv]
// QR data segment bit packer. Characters go in through a queue-style port
// (push/full) with a last flag, and variable-width bit groups come out of a
// queue-style port (empty/pop): 10/7/4 bits for numeric digit triples and
// remainders, 11/6 bits for alphanumeric pairs and an odd tail, 8 bits per
// byte. The sustained rate is one character per clock while pop stays high.
// A group reaches the result ports once the character completing it has
// passed through the classified queue and then the result queue; the back
// end takes no character while the result queue is full. It updates its
// partial-group register in the same cycle that it takes a character. Both
// queues are QueueDepth entries deep. Writing segment_mode drops any partial
// group; write it only while no characters are in flight.
`default_nettype none

`include "qr_segment_bit_packer_defines.svh"

module qr_segment_bit_packer
  import qsbp_pkg::*;
#(
  parameter int QueueDepth = 2
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  segment_mode,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  char_code,
  input  wire logic        is_last,
  output logic             empty,
  input  wire logic        pop,
  output logic [10:0]      group_value,
  output logic [3:0]       group_width,
  output logic             group_last,
  output logic             bad_char
);

  localparam int CW = $bits(class_item_t);
  localparam int GW = $bits(group_t);

  logic        [1:0] mode_reg;
  logic              cfg_we;
  logic              q_push;
  logic              q_pop;
  logic              q_empty;
  class_item_t       q_in;
  class_item_t       q_out;
  logic              r_push;
  logic              r_full;
  group_t            r_in;
  group_t            r_out;
  logic              width_legal;
  logic              short_group;
  logic              byte_group;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  // mode register
  always_ff @(posedge clk) begin
    if (rst) begin
      mode_reg <= MODE_NUMERIC;
    end else if (cfg_we) begin
      mode_reg <= segment_mode;
    end
  end

  qsbp_front u_front (
    .mode_sel  (mode_reg),
    .push      (push),
    .char_code (char_code),
    .is_last   (is_last),
    .q_full    (full),
    .q_push    (q_push),
    .q_item    (q_in)
  );

  // classified character queue
  qsbp_fifo #(.WIDTH(CW), .DEPTH(QueueDepth)) u_class_q (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_in),
    .full  (full),
    .pop   (q_pop),
    .rdata (q_out),
    .empty (q_empty)
  );

  qsbp_back u_back (
    .clk     (clk),
    .rst     (rst),
    .clear   (cfg_we),
    .q_empty (q_empty),
    .q_item  (q_out),
    .q_pop   (q_pop),
    .r_full  (r_full),
    .r_push  (r_push),
    .r_item  (r_in)
  );

  // result queue
  qsbp_fifo #(.WIDTH(GW), .DEPTH(QueueDepth)) u_result_q (
    .clk   (clk),
    .rst   (rst),
    .push  (r_push),
    .wdata (r_in),
    .full  (r_full),
    .pop   (pop),
    .rdata (r_out),
    .empty (empty)
  );

  assign group_value = r_out.value;
  assign group_width = r_out.width;
  assign group_last  = r_out.last;
  assign bad_char    = r_out.bad;

  // width classes seen on the result ports
  assign width_legal = group_width inside {W_NUM1, W_ALN1, W_NUM2, W_BYTE, W_NUM3, W_ALN2};
  assign short_group = !empty && (group_width inside {W_NUM1, W_ALN1, W_NUM2});
  assign byte_group  = !empty && (group_width == W_BYTE);

  // checks
  `QSBP_ASSERT_HOLD(a_width_legal, clk, rst, !empty, width_legal, "illegal group width")
  `QSBP_ASSERT_HOLD(a_short_is_last, clk, rst, short_group, group_last, "short group not last")
  `QSBP_ASSERT_HOLD(a_byte_clean, clk, rst, byte_group, !bad_char, "byte group flagged bad")
  `QSBP_ASSERT_NEXT(a_last_emits, clk, rst, q_pop && q_out.last, !empty, "no group for last item")

endmodule

`default_nettype wire
